### sv/gbf_pkg.sv
`timescale 1ns / 1ps

package gbf_pkg;

    localparam int CMD_W   = 2;
    localparam int VTX_W   = 11;
    localparam int CNT_W   = 10;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_ADD_WA,
        S_ADD_WB,
        S_READ,
        S_RUN_CLR,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_ROOT_FL,
        S_WALK,
        S_EDGE,
        S_DISC,
        S_PUSH,
        S_POP,
        S_SORT_I,
        S_SORT_KEY,
        S_SORT_J,
        S_SORT_CMP
    } state_t;

endpackage

### sv/graph_bridge_finder_top.sv
`timescale 1ns / 1ps

// Bridge finder for an undirected graph held in on-chip memories.
// A command item (command, end_a, end_b) is taken when start is high and busy
// is low. Every item gives exactly one result, shown for one cycle with done.
// The receiver cannot stall; results are never held back.
// Add is answered from idle when refused or a self-loop; otherwise it first writes both
// half-edges (S_ADD_WA, S_ADD_WB). Read is answered from idle when nothing is left,
// otherwise after a bridge memory read (S_READ). Clear is a pass over the adjacency head memory.
// Run clears the discovery memory, walks a search tree from each undiscovered vertex
// up to vertex_count, then insertion-sorts the bridges found; each step is one access
// of a single-port-read memory.
// The vertex_count register is written on the cfg channel, which is always ready.
// After reset the block is busy while the adjacency heads are cleared,
// and then gives no result.

module graph_bridge_finder_top
    import gbf_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [VTX_W-1:0]  end_a,
    input  logic [VTX_W-1:0]  end_b,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [CNT_W-1:0]  bridge_count,
    output logic [VTX_W-1:0]  low_end,
    output logic [VTX_W-1:0]  high_end,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [VTX_W-1:0]  cfg_data
);

    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int VD = MAX_VERTICES + 1;
    localparam int HS = 2 * MAX_EDGES;
    localparam int HW = $clog2(HS + 1);
    localparam int EA = (HS > 1) ? $clog2(HS) : 1;
    localparam int SA = $clog2(MAX_VERTICES);
    localparam int BD = MAX_VERTICES - 1;
    localparam int BA = (BD > 1) ? $clog2(BD) : 1;
    localparam int EW = VW + HW;
    localparam int SW = 4 * VW + HW;
    localparam logic [HW-1:0] NO_LINK = HW'(HS);

    state_t state_reg, state_next;

    logic [VW-1:0]   vc_reg, vc_next;
    logic [HW-1:0]   hc_reg, hc_next;
    logic [SA-1:0]   total_reg, total_next;
    logic [SA-1:0]   cursor_reg, cursor_next;
    logic            run_valid_reg, run_valid_next;
    logic [VW:0]     clr_idx_reg, clr_idx_next;
    logic            clr_cmd_reg, clr_cmd_next;
    logic [VW-1:0]   a_reg, a_next;
    logic [VW-1:0]   b_reg, b_next;
    logic [VW:0]     v_reg, v_next;
    logic [VW-1:0]   counter_reg, counter_next;
    logic [VW-1:0]   depth_reg, depth_next;
    logic [VW-1:0]   cur_vertex_reg, cur_vertex_next;
    logic [VW-1:0]   cur_parent_reg, cur_parent_next;
    logic [HW-1:0]   cur_link_reg, cur_link_next;
    logic [VW-1:0]   cur_low_reg, cur_low_next;
    logic [VW-1:0]   cur_disc_reg, cur_disc_next;
    logic [VW-1:0]   c_reg, c_next;
    logic [SA-1:0]   i_reg, i_next;
    logic [SA-1:0]   j_reg, j_next;
    logic [2*VW-1:0] key_reg, key_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [VW-1:0]     lo_reg, lo_next;
    logic [VW-1:0]     hi_reg, hi_next;
    logic              last_reg, last_next;

    logic            fl_we;
    logic [VW-1:0]   fl_waddr, fl_raddr;
    logic [HW-1:0]   fl_wdata, fl_rdata;
    logic            edge_we;
    logic [EA-1:0]   edge_waddr, edge_raddr;
    logic [EW-1:0]   edge_wdata, edge_rdata;
    logic            disc_we;
    logic [VW-1:0]   disc_waddr, disc_raddr;
    logic [VW-1:0]   disc_wdata, disc_rdata;
    logic            stk_we;
    logic [SA-1:0]   stk_waddr, stk_raddr;
    logic [SW-1:0]   stk_wdata, stk_rdata;
    logic            br_we;
    logic [BA-1:0]   br_waddr, br_raddr;
    logic [2*VW-1:0] br_wdata, br_rdata;

    gbf_ram #(.WIDTH(HW), .DEPTH(VD)) u_first_link (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );

    gbf_ram #(.WIDTH(EW), .DEPTH(HS)) u_edges (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    gbf_ram #(.WIDTH(VW), .DEPTH(VD)) u_disc (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
        .raddr(disc_raddr), .rdata(disc_rdata)
    );

    gbf_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    gbf_ram #(.WIDTH(2 * VW), .DEPTH(BD)) u_bridges (
        .clk(clk), .we(br_we), .waddr(br_waddr), .wdata(br_wdata),
        .raddr(br_raddr), .rdata(br_rdata)
    );

    logic          accept;
    logic          add_range_bad;
    logic          add_full;
    logic          read_empty;
    logic          clr_end;
    logic          root_done;
    logic          link_live;
    logic          walk_end;
    logic [VW-1:0] tgt;
    logic [HW-1:0] tgt_next_link;
    logic          skip_c;
    logic          can_push;
    logic [VW-1:0] p_vertex, p_parent, p_low, p_disc;
    logic [HW-1:0] p_link;
    logic          is_bridge;
    logic          sort_done;
    logic          sort_gt;

    assign accept        = start && !busy;
    assign add_range_bad = (end_a == '0) || (end_b == '0) ||
                           (32'(end_a) > 32'(vc_reg)) || (32'(end_b) > 32'(vc_reg));
    assign add_full      = (32'(hc_reg) + 32'd2) > 32'(HS);
    assign read_empty    = !run_valid_reg || (cursor_reg >= total_reg);
    assign clr_end       = 32'(clr_idx_reg) == 32'(MAX_VERTICES);
    assign root_done     = v_reg > {1'b0, vc_reg};
    assign link_live     = cur_link_reg != NO_LINK;
    assign walk_end      = depth_reg == VW'(1);
    assign tgt           = edge_rdata[EW-1:HW];
    assign tgt_next_link = edge_rdata[HW-1:0];
    assign skip_c        = (tgt == '0) || (tgt > vc_reg) || (tgt == cur_parent_reg);
    assign can_push      = 32'(depth_reg) < 32'(MAX_VERTICES);
    assign {p_vertex, p_parent, p_link, p_low, p_disc} = stk_rdata;
    assign is_bridge     = (cur_low_reg > p_disc) &&
                           (32'(total_reg) < 32'(MAX_VERTICES - 1));
    assign sort_done     = i_reg >= total_reg;
    assign sort_gt       = br_rdata > key_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:      if (clr_end) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_ADD:
                        begin
                            if (!add_range_bad && !add_full && (end_a != end_b))
                                state_next = S_ADD_WA;
                        end
                        CMD_RUN:   state_next = S_RUN_CLR;
                        CMD_READ:  if (!read_empty) state_next = S_READ;
                        CMD_CLEAR: state_next = S_CLR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_WA:   state_next = S_ADD_WB;
            S_ADD_WB:   state_next = S_IDLE;
            S_READ:     state_next = S_IDLE;
            S_RUN_CLR:  if (clr_end) state_next = S_ROOT_RD;
            S_ROOT_RD:  state_next = root_done ? S_SORT_I : S_ROOT_CHK;
            S_ROOT_CHK: state_next = (disc_rdata != '0) ? S_ROOT_RD : S_ROOT_FL;
            S_ROOT_FL:  state_next = S_WALK;
            S_WALK:
            begin
                priority if (link_live) state_next = S_EDGE;
                else if (walk_end)      state_next = S_ROOT_RD;
                else                    state_next = S_POP;
            end
            S_EDGE:     state_next = skip_c ? S_WALK : S_DISC;
            S_DISC:
                state_next = ((disc_rdata == '0) && can_push) ? S_PUSH : S_WALK;
            S_PUSH:     state_next = S_WALK;
            S_POP:      state_next = S_WALK;
            S_SORT_I:   state_next = sort_done ? S_IDLE : S_SORT_KEY;
            S_SORT_KEY: state_next = S_SORT_J;
            S_SORT_J:   state_next = (j_reg == '0) ? S_SORT_I : S_SORT_CMP;
            S_SORT_CMP: state_next = sort_gt ? S_SORT_J : S_SORT_I;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        vc_next         = vc_reg;
        hc_next         = hc_reg;
        total_next      = total_reg;
        cursor_next     = cursor_reg;
        run_valid_next  = run_valid_reg;
        clr_idx_next    = clr_idx_reg;
        clr_cmd_next    = clr_cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        v_next          = v_reg;
        counter_next    = counter_reg;
        depth_next      = depth_reg;
        cur_vertex_next = cur_vertex_reg;
        cur_parent_next = cur_parent_reg;
        cur_link_next   = cur_link_reg;
        cur_low_next    = cur_low_reg;
        cur_disc_next   = cur_disc_reg;
        c_next          = c_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        last_next       = last_reg;

        fl_we      = 1'b0;
        fl_waddr   = a_reg;
        fl_wdata   = hc_reg;
        fl_raddr   = b_reg;
        edge_we    = 1'b0;
        edge_waddr = hc_reg[EA-1:0];
        edge_wdata = {b_reg, fl_rdata};
        edge_raddr = cur_link_reg[EA-1:0];
        disc_we    = 1'b0;
        disc_waddr = c_reg;
        disc_wdata = counter_reg + VW'(1);
        disc_raddr = tgt;
        stk_we     = 1'b0;
        stk_waddr  = SA'(depth_reg - VW'(1));
        stk_wdata  = {cur_vertex_reg, cur_parent_reg, cur_link_reg, cur_low_reg,
                      cur_disc_reg};
        stk_raddr  = SA'(depth_reg - VW'(2));
        br_we      = 1'b0;
        br_waddr   = BA'(total_reg);
        br_wdata   = (p_vertex < cur_vertex_reg) ? {p_vertex, cur_vertex_reg}
                                                 : {cur_vertex_reg, p_vertex};
        br_raddr   = BA'(cursor_reg);

        if (cfg_valid)
        begin
            priority if (cfg_data == '0)
                vc_next = VW'(1);
            else if (32'(cfg_data) > 32'(MAX_VERTICES))
                vc_next = VW'(MAX_VERTICES);
            else
                vc_next = VW'(cfg_data);
        end

        unique case (state_reg)
            S_CLR:
            begin
                fl_we        = 1'b1;
                fl_waddr     = clr_idx_reg[VW-1:0];
                fl_wdata     = NO_LINK;
                clr_idx_next = clr_idx_reg + (VW+1)'(1);
                if (clr_end)
                begin
                    hc_next        = '0;
                    total_next     = '0;
                    cursor_next    = '0;
                    run_valid_next = 1'b0;
                    done_next      = clr_cmd_reg;
                    status_next    = ST_OK;
                    lo_next        = '0;
                    hi_next        = '0;
                    last_next      = 1'b0;
                end
            end
            S_IDLE:
            begin
                fl_raddr = VW'(end_a);
                a_next   = VW'(end_a);
                b_next   = VW'(end_b);
                if (accept)
                begin
                    lo_next   = '0;
                    hi_next   = '0;
                    last_next = 1'b0;
                    unique case (command)
                        CMD_ADD:
                        begin
                            priority if (add_range_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else if (add_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (end_a == end_b)
                            begin
                                done_next      = 1'b1;
                                status_next    = ST_OK;
                                run_valid_next = 1'b0;
                                total_next     = '0;
                                cursor_next    = '0;
                            end
                            else
                            begin
                                status_next = ST_OK;
                            end
                        end
                        CMD_RUN:
                        begin
                            clr_idx_next   = '0;
                            run_valid_next = 1'b0;
                        end
                        CMD_READ:
                        begin
                            br_raddr = BA'(cursor_reg);
                            if (read_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            clr_idx_next = '0;
                            clr_cmd_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_ADD_WA:
            begin
                edge_we    = 1'b1;
                edge_wdata = {b_reg, fl_rdata};
                fl_we      = 1'b1;
                fl_waddr   = a_reg;
                fl_wdata   = hc_reg;
                fl_raddr   = b_reg;
                hc_next    = hc_reg + HW'(1);
            end
            S_ADD_WB:
            begin
                edge_we        = 1'b1;
                edge_wdata     = {a_reg, fl_rdata};
                fl_we          = 1'b1;
                fl_waddr       = b_reg;
                fl_wdata       = hc_reg;
                hc_next        = hc_reg + HW'(1);
                run_valid_next = 1'b0;
                total_next     = '0;
                cursor_next    = '0;
                done_next      = 1'b1;
                status_next    = ST_OK;
            end
            S_READ:
            begin
                lo_next     = br_rdata[2*VW-1:VW];
                hi_next     = br_rdata[VW-1:0];
                cursor_next = cursor_reg + SA'(1);
                last_next   = (cursor_reg + SA'(1)) == total_reg;
                done_next   = 1'b1;
                status_next = ST_OK;
            end
            S_RUN_CLR:
            begin
                disc_we      = 1'b1;
                disc_waddr   = clr_idx_reg[VW-1:0];
                disc_wdata   = '0;
                clr_idx_next = clr_idx_reg + (VW+1)'(1);
                total_next   = '0;
                cursor_next  = '0;
                v_next       = (VW+1)'(1);
                counter_next = '0;
            end
            S_ROOT_RD:
            begin
                disc_raddr = v_reg[VW-1:0];
                i_next     = SA'(1);
            end
            S_ROOT_CHK:
            begin
                fl_raddr = v_reg[VW-1:0];
                if (disc_rdata != '0)
                begin
                    v_next = v_reg + (VW+1)'(1);
                end
                else
                begin
                    disc_we      = 1'b1;
                    disc_waddr   = v_reg[VW-1:0];
                    counter_next = counter_reg + VW'(1);
                end
            end
            S_ROOT_FL:
            begin
                cur_vertex_next = v_reg[VW-1:0];
                cur_parent_next = '0;
                cur_link_next   = fl_rdata;
                cur_low_next    = counter_reg;
                cur_disc_next   = counter_reg;
                depth_next      = VW'(1);
            end
            S_WALK:
            begin
                if (!link_live && walk_end)
                begin
                    v_next = v_reg + (VW+1)'(1);
                end
            end
            S_EDGE:
            begin
                cur_link_next = tgt_next_link;
                c_next        = tgt;
            end
            S_DISC:
            begin
                fl_raddr = c_reg;
                if (disc_rdata != '0)
                begin
                    if (disc_rdata < cur_low_reg)
                        cur_low_next = disc_rdata;
                end
                else if (can_push)
                begin
                    disc_we      = 1'b1;
                    disc_waddr   = c_reg;
                    counter_next = counter_reg + VW'(1);
                    stk_we       = 1'b1;
                end
            end
            S_PUSH:
            begin
                cur_vertex_next = c_reg;
                cur_parent_next = cur_vertex_reg;
                cur_link_next   = fl_rdata;
                cur_low_next    = counter_reg;
                cur_disc_next   = counter_reg;
                depth_next      = depth_reg + VW'(1);
            end
            S_POP:
            begin
                if (is_bridge)
                begin
                    br_we      = 1'b1;
                    total_next = total_reg + SA'(1);
                end
                cur_vertex_next = p_vertex;
                cur_parent_next = p_parent;
                cur_link_next   = p_link;
                cur_low_next    = (cur_low_reg < p_low) ? cur_low_reg : p_low;
                cur_disc_next   = p_disc;
                depth_next      = depth_reg - VW'(1);
            end
            S_SORT_I:
            begin
                br_raddr = BA'(i_reg);
                j_next   = i_reg;
                if (sort_done)
                begin
                    run_valid_next = 1'b1;
                    cursor_next    = '0;
                    done_next      = 1'b1;
                    status_next    = ST_OK;
                    lo_next        = '0;
                    hi_next        = '0;
                    last_next      = 1'b0;
                end
            end
            S_SORT_KEY:
            begin
                key_next = br_rdata;
            end
            S_SORT_J:
            begin
                br_raddr = BA'(j_reg - SA'(1));
                if (j_reg == '0)
                begin
                    br_we    = 1'b1;
                    br_waddr = '0;
                    br_wdata = key_reg;
                    i_next   = i_reg + SA'(1);
                end
            end
            S_SORT_CMP:
            begin
                br_we    = 1'b1;
                br_waddr = BA'(j_reg);
                if (sort_gt)
                begin
                    br_wdata = br_rdata;
                    j_next   = j_reg - SA'(1);
                end
                else
                begin
                    br_wdata = key_reg;
                    i_next   = i_reg + SA'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            vc_reg        <= VW'(1);
            hc_reg        <= '0;
            total_reg     <= '0;
            cursor_reg    <= '0;
            run_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
            clr_cmd_reg   <= 1'b0;
            depth_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            hc_reg        <= hc_next;
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            run_valid_reg <= run_valid_next;
            clr_idx_reg   <= clr_idx_next;
            clr_cmd_reg   <= clr_cmd_next;
            depth_reg     <= depth_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        v_reg          <= v_next;
        counter_reg    <= counter_next;
        cur_vertex_reg <= cur_vertex_next;
        cur_parent_reg <= cur_parent_next;
        cur_link_reg   <= cur_link_next;
        cur_low_reg    <= cur_low_next;
        cur_disc_reg   <= cur_disc_next;
        c_reg          <= c_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        key_reg        <= key_next;
        status_reg     <= status_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        last_reg       <= last_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign status       = status_reg;
    assign bridge_count = run_valid_reg ? CNT_W'(total_reg) : '0;
    assign low_end      = VTX_W'(lo_reg);
    assign high_end     = VTX_W'(hi_reg);
    assign last         = last_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result shown outside idle");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || busy))
        else $error("accepted item neither answered nor in progress");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= 32'(MAX_VERTICES))
        else $error("walk stack overflow");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(MAX_VERTICES - 1))
        else $error("bridge list overflow");

    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && last_reg) |-> (status_reg == ST_OK && run_valid_reg))
        else $error("last flag on a failed read");

endmodule

### sv/gbf_ram.sv
`timescale 1ns / 1ps

module gbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sim/graph_bridge_finder_checker.sv
`timescale 1ns / 1ps

module graph_bridge_finder_checker
    import gbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [VTX_W-1:0]  end_a,
    input  logic [VTX_W-1:0]  end_b,
    input  logic              done,
    input  logic [STAT_W-1:0] status,
    input  logic [CNT_W-1:0]  bridge_count,
    input  logic [VTX_W-1:0]  low_end,
    input  logic [VTX_W-1:0]  high_end,
    input  logic              last,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [VTX_W-1:0]  cfg_data,
    output int                errors,
    output int                pending,
    output int                answers_seen,
    output int                bridges_read
);

    localparam int NV = 1024;
    localparam int NE = 4096;
    localparam int SLOTS = 2 * NE;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic [VTX_W-1:0]  lo;
        logic [VTX_W-1:0]  hi;
        logic              last;
    } answer_t;

    answer_t answers_due[$];

    int  n_vert;
    int  tgt[SLOTS];
    int  nxt[SLOTS];
    int  head[NV + 1];
    int  n_half;
    int  disc[NV + 1];
    int  st_v[NV], st_p[NV], st_l[NV], st_low[NV];
    int  br_lo[NV], br_hi[NV];
    int  n_br;
    int  cursor;
    bit  searched;

    function automatic void wipe_graph();
        for (int i = 0; i <= NV; i++)
            head[i] = SLOTS;
        n_half = 0;
        n_br = 0;
        cursor = 0;
        searched = 0;
    endfunction

    function automatic void add_link(int f, int t);
        tgt[n_half] = t;
        nxt[n_half] = head[f];
        head[f] = n_half;
        n_half++;
    endfunction

    function automatic void note_bridge(int a, int b);
        if (n_br >= NV - 1)
            return;
        br_lo[n_br] = a < b ? a : b;
        br_hi[n_br] = a < b ? b : a;
        n_br++;
    endfunction

    function automatic void walk_tree(int root, inout int stamp);
        int sp;
        int h;
        int c;
        int kid;
        int kid_low;
        stamp++;
        disc[root] = stamp;
        st_v[0] = root;
        st_p[0] = 0;
        st_l[0] = head[root];
        st_low[0] = stamp;
        sp = 1;
        while (sp > 0)
        begin
            if (st_l[sp-1] < SLOTS)
            begin
                h = st_l[sp-1];
                c = tgt[h];
                st_l[sp-1] = nxt[h];
                if (c == 0 || c > n_vert || c == st_p[sp-1])
                    continue;
                if (disc[c] != 0)
                begin
                    if (disc[c] < st_low[sp-1])
                        st_low[sp-1] = disc[c];
                end
                else if (sp < NV)
                begin
                    stamp++;
                    disc[c] = stamp;
                    st_v[sp] = c;
                    st_p[sp] = st_v[sp-1];
                    st_l[sp] = head[c];
                    st_low[sp] = stamp;
                    sp++;
                end
            end
            else
            begin
                kid = st_v[sp-1];
                kid_low = st_low[sp-1];
                sp--;
                if (sp > 0)
                begin
                    if (kid_low > disc[st_v[sp-1]])
                        note_bridge(st_v[sp-1], kid);
                    if (kid_low < st_low[sp-1])
                        st_low[sp-1] = kid_low;
                end
            end
        end
    endfunction

    function automatic void find_bridges();
        int stamp;
        int a;
        int b;
        int j;
        stamp = 0;
        for (int i = 0; i <= NV; i++)
            disc[i] = 0;
        n_br = 0;
        cursor = 0;
        for (int v = 1; v <= n_vert; v++)
            if (disc[v] == 0)
                walk_tree(v, stamp);
        for (int i = 1; i < n_br; i++)
        begin
            a = br_lo[i];
            b = br_hi[i];
            j = i;
            while (j > 0 && (br_lo[j-1] > a || (br_lo[j-1] == a && br_hi[j-1] > b)))
            begin
                br_lo[j] = br_lo[j-1];
                br_hi[j] = br_hi[j-1];
                j--;
            end
            br_lo[j] = a;
            br_hi[j] = b;
        end
        searched = 1;
    endfunction

    function automatic answer_t apply_command(logic [CMD_W-1:0] cmd, int a, int b);
        answer_t r;
        r = '0;
        case (cmd)
            CMD_ADD:
            begin
                if (a == 0 || b == 0 || a > n_vert || b > n_vert)
                    r.status = ST_RANGE;
                else if (n_half + 2 > SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    if (a != b)
                    begin
                        add_link(a, b);
                        add_link(b, a);
                    end
                    searched = 0;
                    n_br = 0;
                    cursor = 0;
                end
            end
            CMD_RUN:
                find_bridges();
            CMD_READ:
            begin
                if (!searched || cursor >= n_br)
                    r.status = ST_NONE;
                else
                begin
                    r.lo = VTX_W'(br_lo[cursor]);
                    r.hi = VTX_W'(br_hi[cursor]);
                    cursor++;
                    r.last = (cursor == n_br);
                end
            end
            default:
                wipe_graph();
        endcase
        r.count = searched ? CNT_W'(n_br) : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int v;
        if (!rst_n)
        begin
            n_vert = 1;
            for (int i = 0; i <= NV; i++)
                disc[i] = 0;
            wipe_graph();
            answers_due.delete();
            errors <= 0;
            pending <= 0;
            answers_seen <= 0;
            bridges_read <= 0;
        end
        else
        begin
            if (done)
            begin
                answers_seen <= answers_seen + 1;
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time,
                             {status, bridge_count, low_end, high_end, last});
                    errors <= errors + 1;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.status == ST_OK && want.hi != 0)
                        bridges_read <= bridges_read + 1;
                    if (want.status !== status || want.count !== bridge_count ||
                        want.lo !== low_end || want.hi !== high_end || want.last !== last)
                    begin
                        $display("%0t: mismatch, expected st=%0d cnt=%0d lo=%0d hi=%0d last=%0d",
                                 $time, want.status, want.count, want.lo, want.hi, want.last);
                        $display("%0t:           actual   st=%0d cnt=%0d lo=%0d hi=%0d last=%0d",
                                 $time, status, bridge_count, low_end, high_end, last);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                v = int'(cfg_data);
                if (v == 0)
                    v = 1;
                if (v > NV)
                    v = NV;
                n_vert = v;
            end
            if (start && !busy)
                answers_due = {answers_due,
                               apply_command(command, int'(end_a), int'(end_b))};
            pending <= answers_due.size();
        end
    end

endmodule

### sim/graph_bridge_finder_top_tb.sv
`timescale 1ns / 1ps

module graph_bridge_finder_top_tb
    import gbf_pkg::*;
();

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  command;
    logic [VTX_W-1:0]  end_a;
    logic [VTX_W-1:0]  end_b;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  bridge_count;
    logic [VTX_W-1:0]  low_end;
    logic [VTX_W-1:0]  high_end;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [VTX_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    int                answers_seen;
    int                bridges_read;
    int                quiet_cycles;
    int                idle_pct;
    int                items_sent;

    localparam int WATCHDOG = 200000;

    graph_bridge_finder_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .end_a(end_a), .end_b(end_b),
        .done(done), .status(status), .bridge_count(bridge_count),
        .low_end(low_end), .high_end(high_end), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    graph_bridge_finder_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .end_a(end_a), .end_b(end_b),
        .done(done), .status(status), .bridge_count(bridge_count),
        .low_end(low_end), .high_end(high_end), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .answers_seen(answers_seen),
        .bridges_read(bridges_read)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(logic [CMD_W-1:0] cmd, int a, int b);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        end_a <= VTX_W'(a);
        end_b <= VTX_W'(b);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_vertices(int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= VTX_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // After a clear, a small random graph: chain, a few chords, out-of-range adds.
    task automatic random_graph(int nv);
        int n_edges;
        n_edges = $urandom_range(nv + 3, 1);
        send(CMD_CLEAR, $urandom, $urandom);
        for (int i = 0; i < n_edges; i++)
        begin
            if ($urandom_range(9) == 0)
                send(CMD_ADD, $urandom_range(2047), $urandom_range(2047));
            else if ($urandom_range(2) == 0)
                send(CMD_ADD, $urandom_range(nv, 1), $urandom_range(nv, 1));
            else
                send(CMD_ADD, i % nv + 1, (i + 1) % nv + 1);
        end
        send(CMD_RUN, $urandom, $urandom);
        repeat ($urandom_range(nv, 1))
            send(CMD_READ, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        command = CMD_ADD;
        end_a = '0;
        end_b = '0;
        cfg_valid = 0;
        cfg_data = '0;
        idle_pct = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: reads before a search, range errors, self-loops, clamped vertex counts.
        send(CMD_READ, 0, 0);
        send(CMD_ADD, 1, 1);
        send(CMD_ADD, 1, 2);
        send(CMD_RUN, 0, 0);
        send(CMD_READ, 0, 0);
        set_vertices(0);
        set_vertices(2047);
        send(CMD_ADD, 0, 5);
        send(CMD_ADD, 1025, 3);
        send(CMD_ADD, 1024, 1);
        send(CMD_ADD, 1, 2);
        send(CMD_ADD, 2, 1);
        send(CMD_ADD, 2, 3);
        send(CMD_ADD, 3, 3);
        send(CMD_ADD, 3, 4);
        send(CMD_ADD, 4, 2);
        send(CMD_RUN, 0, 0);
        send(CMD_READ, 0, 0);
        send(CMD_READ, 0, 0);
        send(CMD_READ, 0, 0);
        send(CMD_ADD, 5, 6);
        send(CMD_READ, 0, 0);
        // Shrinking the vertex count hides edges to higher vertices.
        set_vertices(3);
        send(CMD_RUN, 0, 0);
        send(CMD_READ, 0, 0);
        send(CMD_READ, 0, 0);
        send(CMD_CLEAR, 2047, 2047);
        send(CMD_READ, 0, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 20 : ((phase == 1) ? 54 : 0);
            set_vertices($urandom_range(12, 2));
            for (int g = 0; g < 2; g++)
                random_graph(chk.n_vert);
            drain();
        end
        set_vertices(1);
        send(CMD_ADD, 1, 1);
        send(CMD_RUN, 0, 0);
        send(CMD_READ, 0, 0);

        drain();
        $display("Sent %0d items with %0d results, %0d bridges read, over vertex counts 1..1024.",
                 items_sent, answers_seen, bridges_read);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
